>>> hdl/pfdr_pkg.sv
// Shared types and constants for the page framebuffer with dirty refresh.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pfdr_pkg;

  localparam int KIND_W   = 2;
  localparam int COLUMN_W = 7;
  localparam int ROW_W    = 6;
  localparam int PAGE_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int GROUP_W  = 3;

  localparam int DEF_PAGES       = 8;
  localparam int DEF_COLUMNS     = 128;
  localparam int DEF_GROUP_WIDTH = 16;

  localparam logic [BYTE_W-1:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [BYTE_W-1:0] CMD_COL_HI    = 8'h10;
  localparam logic [BYTE_W-1:0] NIBBLE_MASK   = 8'h0F;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_REFRESH = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PIX_WR,
    ST_FCLEAR,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    EMIT_DATA,
    EMIT_PAGE,
    EMIT_COL_HI,
    EMIT_COL_LO
  } emit_step_t;

  typedef struct packed {
    logic              valid;
    logic              is_data;
    logic [BYTE_W-1:0] data;
    logic              last;
  } beat_t;

endpackage

>>> hdl/pfdr_item_if.sv
// Input channel of the framebuffer: one beat is one command item.
// Depends on pfdr_pkg for field widths.
`timescale 1ns / 1ps

interface pfdr_item_if import pfdr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [COLUMN_W-1:0] column;
  logic [ROW_W-1:0]    row;
  logic [PAGE_W-1:0]   page;
  logic [BYTE_W-1:0]   byte_value;
  logic                pixel_on;
  logic [GROUP_W-1:0]  column_group;

  modport source (output valid, kind, column, row, page, byte_value, pixel_on, column_group,
                  input ready);
  modport sink   (input valid, kind, column, row, page, byte_value, pixel_on, column_group,
                  output ready);
endinterface

>>> hdl/pfdr_result_if.sv
// Output channel of the framebuffer: one beat is one byte for the panel.
// Depends on pfdr_pkg for field widths.
`timescale 1ns / 1ps

interface pfdr_result_if import pfdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_data;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source (output valid, is_data, out_byte, last_of_run, input ready);
  modport sink   (input valid, is_data, out_byte, last_of_run, output ready);
endinterface

>>> hdl/page_framebuffer_dirty_refresh.sv
// Page-organized monochrome framebuffer with a shadow of the panel contents. After reset
// the block clears both RAMs and takes no item meanwhile. A byte write goes to the frame
// RAM as the item is accepted, a pixel write is a read-modify-write on the frame RAM, and
// a frame clear sweeps the frame RAM, one RAM entry a cycle. A refresh scans the columns
// of one group and sends four beats for each dirty byte; a stalled result channel holds
// the refresh.
// Depends on pfdr_pkg, the channel interfaces, pfdr_ctrl and pfdr_obuf.
`timescale 1ns / 1ps

module page_framebuffer_dirty_refresh import pfdr_pkg::*; #(
  parameter int PAGES       = DEF_PAGES,
  parameter int COLUMNS     = DEF_COLUMNS,
  parameter int GROUP_WIDTH = DEF_GROUP_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  pfdr_item_if.sink     item,
  pfdr_result_if.source result
);

  beat_t push;
  logic  can_push;

  pfdr_ctrl #(
    .PAGES       (PAGES),
    .COLUMNS     (COLUMNS),
    .GROUP_WIDTH (GROUP_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .can_push (can_push),
    .push     (push)
  );

  pfdr_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .can_push (can_push),
    .result   (result)
  );

endmodule

>>> hdl/pfdr_ram.sv
// Byte-wide simple dual-port RAM: one write and one registered read a cycle.
// Depends on pfdr_pkg for the data width.
`timescale 1ns / 1ps

module pfdr_ram import pfdr_pkg::*; #(
  parameter int DEPTH = DEF_PAGES * DEF_COLUMNS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [BYTE_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [BYTE_W-1:0]        rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/pfdr_ctrl.sv
// Sequencer around the frame and shadow RAMs: writes, clear sweeps and refresh scan.
// Depends on pfdr_pkg, pfdr_item_if and pfdr_ram.
`timescale 1ns / 1ps

module pfdr_ctrl import pfdr_pkg::*; #(
  parameter int PAGES       = DEF_PAGES,
  parameter int COLUMNS     = DEF_COLUMNS,
  parameter int GROUP_WIDTH = DEF_GROUP_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  pfdr_item_if.sink   item,
  input  logic        can_push,
  output beat_t       push
);

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = (GROUP_WIDTH > 1) ? $clog2(GROUP_WIDTH) : 1;
  localparam int CXW   = COLUMN_W + 1;

  state_t            state, state_next;
  emit_step_t        step;
  logic [IW-1:0]     idx;
  logic              pend;
  logic [BYTE_W-1:0] pend_byte;
  logic [BYTE_W-1:0] cur_byte;
  logic [PAGE_W-1:0] ref_page;
  logic [GROUP_W-1:0] ref_group;
  logic [AW-1:0]     swp;
  logic [AW-1:0]     pix_addr;
  logic [BYTE_W-1:0] pix_mask;
  logic              pix_on;

  logic              accept;
  kind_t             kind;
  logic [PAGE_W-1:0] pix_pg;
  logic              pix_ok, byte_ok, ref_ok;
  logic [AW-1:0]     item_pix_addr, item_byte_addr;
  logic [CXW-1:0]    cur_col, nxt_col;
  logic [AW-1:0]     ref_addr, nxt_addr;
  logic              idx_last, scan_done_next, col_ok, differ, swp_last;

  logic              frame_we, shadow_we;
  logic [AW-1:0]     frame_waddr, shadow_waddr, raddr;
  logic [BYTE_W-1:0] frame_wdata, shadow_wdata;
  logic [BYTE_W-1:0] frame_rd, shadow_rd;
  logic              emit_want;

  pfdr_ram #(.DEPTH(DEPTH)) u_frame (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .raddr (raddr),
    .rdata (frame_rd)
  );

  pfdr_ram #(.DEPTH(DEPTH)) u_shadow (
    .clk   (clk),
    .we    (shadow_we),
    .waddr (shadow_waddr),
    .wdata (shadow_wdata),
    .raddr (raddr),
    .rdata (shadow_rd)
  );

  // Item decode
  always_comb begin
    accept         = item.valid && item.ready;
    kind           = kind_t'(item.kind);
    pix_pg         = PAGE_W'(item.row[ROW_W-1:3]);
    pix_ok         = (int'(pix_pg) < PAGES) && (int'(item.column) < COLUMNS);
    byte_ok        = (int'(item.page) < PAGES) && (int'(item.column) < COLUMNS);
    ref_ok         = int'(item.page) < PAGES;
    item_pix_addr  = AW'(int'(pix_pg) * COLUMNS + int'(item.column));
    item_byte_addr = AW'(int'(item.page) * COLUMNS + int'(item.column));
  end

  // Refresh scan position
  always_comb begin
    cur_col        = CXW'(ref_group) * CXW'(GROUP_WIDTH) + CXW'(idx);
    nxt_col        = cur_col + CXW'(1);
    ref_addr       = AW'(int'(ref_page) * COLUMNS + int'(cur_col));
    nxt_addr       = AW'(int'(ref_page) * COLUMNS + int'(nxt_col));
    idx_last       = (idx == IW'(GROUP_WIDTH - 1));
    col_ok         = int'(cur_col) < COLUMNS;
    scan_done_next = idx_last || (int'(nxt_col) >= COLUMNS);
    differ         = (frame_rd != shadow_rd);
    swp_last       = (swp == AW'(DEPTH - 1));
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (swp_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_PIXEL:   state_next = pix_ok ? ST_PIX_WR : ST_IDLE;
            KIND_BYTE:    state_next = ST_IDLE;
            KIND_CLEAR:   state_next = ST_FCLEAR;
            KIND_REFRESH: state_next = ref_ok ? ST_SCAN_RD : ST_IDLE;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_PIX_WR:  state_next = ST_IDLE;
      ST_FCLEAR: begin
        if (swp_last) state_next = ST_IDLE;
      end
      ST_SCAN_RD: state_next = col_ok ? ST_SCAN_CMP : ST_FINISH;
      ST_SCAN_CMP: begin
        if (differ) state_next = ST_EMIT;
        else if (scan_done_next) state_next = ST_FINISH;
      end
      ST_EMIT: begin
        if (can_push && step == EMIT_COL_LO) begin
          state_next = scan_done_next ? ST_FINISH : ST_SCAN_RD;
        end
      end
      ST_FINISH: begin
        if (!pend || can_push) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: RAM ports, input ready, output beat
  always_comb begin
    item.ready   = (state == ST_IDLE);
    frame_we     = 1'b0;
    frame_waddr  = swp;
    frame_wdata  = '0;
    shadow_we    = 1'b0;
    shadow_waddr = swp;
    shadow_wdata = '0;
    raddr        = item_pix_addr;
    emit_want    = 1'b0;
    push         = '0;
    case (state)
      ST_INIT: begin
        frame_we  = 1'b1;
        shadow_we = 1'b1;
      end
      ST_IDLE: begin
        if (accept && kind == KIND_BYTE && byte_ok) begin
          frame_we    = 1'b1;
          frame_waddr = item_byte_addr;
          frame_wdata = item.byte_value;
        end
      end
      ST_PIX_WR: begin
        frame_we    = 1'b1;
        frame_waddr = pix_addr;
        frame_wdata = pix_on ? (frame_rd | pix_mask) : (frame_rd & ~pix_mask);
      end
      ST_FCLEAR: begin
        frame_we = 1'b1;
      end
      ST_SCAN_RD: begin
        raddr = ref_addr;
      end
      ST_SCAN_CMP: begin
        raddr        = nxt_addr;
        shadow_waddr = ref_addr;
        shadow_wdata = frame_rd;
        shadow_we    = differ;
      end
      ST_EMIT: begin
        raddr     = ref_addr;
        emit_want = 1'b1;
        case (step)
          EMIT_DATA: begin
            push.is_data = 1'b1;
            push.data    = pend_byte;
          end
          EMIT_PAGE:   push.data = CMD_PAGE_BASE + BYTE_W'(ref_page);
          EMIT_COL_HI: push.data = CMD_COL_HI | {4'b0, cur_col[7:4]};
          EMIT_COL_LO: push.data = BYTE_W'(cur_col) & NIBBLE_MASK;
          default:     push.data = '0;
        endcase
      end
      ST_FINISH: begin
        emit_want    = pend;
        push.is_data = 1'b1;
        push.data    = pend_byte;
        push.last    = 1'b1;
      end
      default: ;
    endcase
    push.valid = emit_want && can_push;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      swp   <= '0;
      pend  <= 1'b0;
      idx   <= '0;
      step  <= EMIT_DATA;
    end else begin
      state <= state_next;
      case (state)
        ST_INIT, ST_FCLEAR: begin
          swp <= swp + AW'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            swp       <= '0;
            idx       <= '0;
            pend      <= 1'b0;
            ref_page  <= item.page;
            ref_group <= item.column_group;
            pix_addr  <= item_pix_addr;
            pix_mask  <= BYTE_W'(1) << item.row[2:0];
            pix_on    <= item.pixel_on;
          end
        end
        ST_SCAN_CMP: begin
          if (differ) begin
            cur_byte <= frame_rd;
            step     <= pend ? EMIT_DATA : EMIT_PAGE;
          end else if (!scan_done_next) begin
            idx <= idx + IW'(1);
          end
        end
        ST_EMIT: begin
          if (can_push) begin
            step <= emit_step_t'(step + 2'd1);
            if (step == EMIT_COL_LO) begin
              // hold the data byte until the next dirty column or the scan end
              pend      <= 1'b1;
              pend_byte <= cur_byte;
              if (!scan_done_next) idx <= idx + IW'(1);
            end
          end
        end
        ST_FINISH: begin
          if (can_push) pend <= 1'b0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    (push.valid && push.last) |-> push.is_data)
    else $error("end of run on a command byte");

  a_last_then_idle: assert property (@(posedge clk) disable iff (rst)
    (push.valid && push.last) |=> (state == ST_IDLE))
    else $error("sequencer busy after end of run");

  a_pend_in_refresh: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == ST_SCAN_RD || state == ST_SCAN_CMP ||
              state == ST_EMIT || state == ST_FINISH))
    else $error("pending data byte outside a refresh");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_CMP) |-> (int'(cur_col) < COLUMNS))
    else $error("refresh compares a column beyond the panel");
`endif

endmodule

>>> hdl/pfdr_obuf.sv
// Output register that parts the sequencer from the result channel.
// Depends on pfdr_pkg and pfdr_result_if.
`timescale 1ns / 1ps

module pfdr_obuf import pfdr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  beat_t         push,
  output logic          can_push,
  pfdr_result_if.source result
);

  logic              valid;
  logic              is_data;
  logic [BYTE_W-1:0] data;
  logic              last;

  always_comb begin
    can_push           = !valid || result.ready;
    result.valid       = valid;
    result.is_data     = is_data;
    result.out_byte    = data;
    result.last_of_run = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push.valid) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      is_data <= push.is_data;
      data    <= push.data;
      last    <= push.last;
    end
  end

endmodule

>>> tb/pfdr_checker.sv
// Scoreboard for the page framebuffer: mirrors the frame and shadow stores from the
// accepted command beats and checks every panel byte that comes out, in order.
// Depends on pfdr_pkg and the two channel interfaces.
`timescale 1ns / 1ps

module pfdr_checker import pfdr_pkg::*; #(
  parameter int PAGES       = DEF_PAGES,
  parameter int COLUMNS     = DEF_COLUMNS,
  parameter int GROUP_WIDTH = DEF_GROUP_WIDTH
) (
  input  logic   clk,
  input  logic   rst,
  pfdr_item_if   item_ch,
  pfdr_result_if result_ch,
  output int     mismatches,
  output int     bytes_pending
);

  localparam int DEPTH = PAGES * COLUMNS;

  typedef struct packed {
    logic              is_data;
    logic [BYTE_W-1:0] value;
    logic              last;
  } panel_byte_t;

  logic [BYTE_W-1:0] frame_mem  [DEPTH];
  logic [BYTE_W-1:0] shadow_mem [DEPTH];
  panel_byte_t       bytes_due [$];
  int                fail_total = 0;

  task automatic report_mismatch(string msg);
    fail_total++;
    if (fail_total <= 50) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Update the mirrored stores and queue the bytes a refresh sends.
  task automatic apply_command(kind_t kind, logic [COLUMN_W-1:0] column,
                               logic [ROW_W-1:0] row, logic [PAGE_W-1:0] page,
                               logic [BYTE_W-1:0] byte_value, logic pixel_on,
                               logic [GROUP_W-1:0] group);
    panel_byte_t       run [$];
    int unsigned       pg, col, idx, i;
    logic [BYTE_W-1:0] page_cmd, hi_cmd, lo_cmd;
    case (kind)
      KIND_PIXEL: begin
        pg = row >> 3;
        if (pg < PAGES && column < COLUMNS) begin
          idx = pg * COLUMNS + column;
          frame_mem[idx][row[2:0]] = pixel_on;
        end
      end
      KIND_BYTE: begin
        if (page < PAGES && column < COLUMNS) frame_mem[page * COLUMNS + column] = byte_value;
      end
      KIND_CLEAR: begin
        foreach (frame_mem[j]) frame_mem[j] = '0;
      end
      KIND_REFRESH: begin
        if (page < PAGES) begin
          page_cmd = CMD_PAGE_BASE + BYTE_W'(page);
          for (i = 0; i < GROUP_WIDTH; i++) begin
            col = group * GROUP_WIDTH + i;
            if (col < COLUMNS) begin
              idx = page * COLUMNS + col;
              if (frame_mem[idx] != shadow_mem[idx]) begin
                shadow_mem[idx] = frame_mem[idx];
                hi_cmd = CMD_COL_HI | (BYTE_W'(col >> 4) & NIBBLE_MASK);
                lo_cmd = BYTE_W'(col) & NIBBLE_MASK;
                run.push_back('{is_data: 1'b0, value: page_cmd, last: 1'b0});
                run.push_back('{is_data: 1'b0, value: hi_cmd, last: 1'b0});
                run.push_back('{is_data: 1'b0, value: lo_cmd, last: 1'b0});
                run.push_back('{is_data: 1'b1, value: frame_mem[idx], last: 1'b0});
              end
            end
          end
          // mark the final byte of this refresh
          if (run.size() > 0) begin
            run[run.size() - 1].last = 1'b1;
            foreach (run[j]) bytes_due.push_back(run[j]);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_byte();
    panel_byte_t want;
    if (bytes_due.size() == 0) begin
      report_mismatch($sformatf("unexpected byte is_data=%0b byte=%02h last=%0b",
                                result_ch.is_data, result_ch.out_byte,
                                result_ch.last_of_run));
    end else begin
      want = bytes_due.pop_front();
      if (result_ch.is_data !== want.is_data || result_ch.out_byte !== want.value ||
          result_ch.last_of_run !== want.last)
        report_mismatch($sformatf(
          "got is_data=%0b byte=%02h last=%0b, want is_data=%0b byte=%02h last=%0b",
          result_ch.is_data, result_ch.out_byte, result_ch.last_of_run,
          want.is_data, want.value, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (frame_mem[j]) begin
        frame_mem[j]  = '0;
        shadow_mem[j] = '0;
      end
      bytes_due.delete();
    end else begin
      // a byte out never belongs to a command accepted on the same edge
      if (result_ch.valid && result_ch.ready) check_byte();
      if (item_ch.valid && item_ch.ready)
        apply_command(kind_t'(item_ch.kind), item_ch.column, item_ch.row, item_ch.page,
                      item_ch.byte_value, item_ch.pixel_on, item_ch.column_group);
    end
    mismatches    <= fail_total;
    bytes_pending <= bytes_due.size();
  end

endmodule

>>> tb/testbench.sv
// Top of the framebuffer testbench: clock, reset, command stimulus and result-side
// backpressure, with the verdict. Depends on pfdr_pkg, the channel interfaces,
// pfdr_checker and the page_framebuffer_dirty_refresh block.
`timescale 1ns / 1ps

module testbench;
  import pfdr_pkg::*;

  typedef struct packed {
    kind_t               kind;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic [PAGE_W-1:0]   page;
    logic [BYTE_W-1:0]   byte_value;
    logic                pixel_on;
    logic [GROUP_W-1:0]  column_group;
  } panel_cmd_t;

  logic clk = 1'b0;
  logic rst;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   items_sent = 0;
  int   mismatches;
  int   bytes_pending;
  int   idle_by_phase  [4] = '{0, 50, 0, 8};
  int   stall_by_phase [4] = '{0, 0, 50, 8};

  pfdr_item_if   item_ch ();
  pfdr_result_if result_ch ();

  page_framebuffer_dirty_refresh u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  pfdr_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_ch       (item_ch),
    .result_ch     (result_ch),
    .mismatches    (mismatches),
    .bytes_pending (bytes_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Fields a command does not use still carry random values.
  function automatic panel_cmd_t noise_cmd();
    panel_cmd_t c;
    case ($urandom_range(2))
      0:       c.kind = KIND_PIXEL;
      1:       c.kind = KIND_BYTE;
      default: c.kind = KIND_REFRESH;
    endcase
    c.column       = COLUMN_W'($urandom);
    c.row          = ROW_W'($urandom);
    c.page         = PAGE_W'($urandom);
    c.byte_value   = BYTE_W'($urandom);
    c.pixel_on     = 1'($urandom);
    c.column_group = GROUP_W'($urandom);
    return c;
  endfunction

  function automatic panel_cmd_t pixel_cmd(int col, int row, bit on);
    panel_cmd_t c = noise_cmd();
    c.kind     = KIND_PIXEL;
    c.column   = COLUMN_W'(col);
    c.row      = ROW_W'(row);
    c.pixel_on = on;
    return c;
  endfunction

  function automatic panel_cmd_t byte_cmd(int pg, int col, int val);
    panel_cmd_t c = noise_cmd();
    c.kind       = KIND_BYTE;
    c.page       = PAGE_W'(pg);
    c.column     = COLUMN_W'(col);
    c.byte_value = BYTE_W'(val);
    return c;
  endfunction

  function automatic panel_cmd_t refresh_cmd(int pg, int grp);
    panel_cmd_t c = noise_cmd();
    c.kind         = KIND_REFRESH;
    c.page         = PAGE_W'(pg);
    c.column_group = GROUP_W'(grp);
    return c;
  endfunction

  function automatic panel_cmd_t clear_cmd();
    panel_cmd_t c = noise_cmd();
    c.kind = KIND_CLEAR;
    return c;
  endfunction

  task automatic send_cmd(panel_cmd_t c);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.kind         <= c.kind;
    item_ch.column       <= c.column;
    item_ch.row          <= c.row;
    item_ch.page         <= c.page;
    item_ch.byte_value   <= c.byte_value;
    item_ch.pixel_on     <= c.pixel_on;
    item_ch.column_group <= c.column_group;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
  endtask

  // Hold the command channel until every queued panel byte has come out.
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (bytes_pending != 0);
  endtask

  // Mostly a burst of writes into one page/group followed by its refresh.
  task automatic random_round();
    int unsigned pick, pg, grp, n, i;
    pick = $urandom_range(99);
    if (pick < 2) begin
      send_cmd(clear_cmd());
    end else if (pick < 14) begin
      send_cmd(noise_cmd());
    end else begin
      pg  = $urandom_range(7);
      grp = $urandom_range(7);
      if ($urandom_range(7) == 0) begin
        // rewrite the whole group so nearly every byte goes out
        for (i = 0; i < DEF_GROUP_WIDTH; i++)
          send_cmd(byte_cmd(pg, grp * DEF_GROUP_WIDTH + i, $urandom_range(255)));
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          if ($urandom_range(1))
            send_cmd(byte_cmd(pg, grp * DEF_GROUP_WIDTH + $urandom_range(15),
                              $urandom_range(255)));
          else
            send_cmd(pixel_cmd(grp * DEF_GROUP_WIDTH + $urandom_range(15),
                               pg * 8 + $urandom_range(7), $urandom_range(1)));
        end
      end
      // drop the refresh now and then to leave stale bytes behind
      if ($urandom_range(9) != 0) send_cmd(refresh_cmd(pg, grp));
      if ($urandom_range(39) == 0) drain_results();
    end
  endtask

  initial begin
    int target;
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.kind         = KIND_PIXEL;
    item_ch.column       = '0;
    item_ch.row          = '0;
    item_ch.page         = '0;
    item_ch.byte_value   = '0;
    item_ch.pixel_on     = 1'b0;
    item_ch.column_group = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // corners of the store, pixel on and off, clean and dirty groups
    send_cmd(byte_cmd(0, 0, 'hFF));
    send_cmd(byte_cmd(7, 127, 'hA5));
    send_cmd(pixel_cmd(127, 62, 1'b1));
    send_cmd(pixel_cmd(127, 63, 1'b0));
    send_cmd(pixel_cmd(0, 0, 1'b0));
    send_cmd(pixel_cmd(16, 8, 1'b1));
    send_cmd(refresh_cmd(0, 0));
    send_cmd(refresh_cmd(7, 7));
    send_cmd(refresh_cmd(7, 7));
    send_cmd(refresh_cmd(1, 1));
    send_cmd(byte_cmd(3, 40, 'h00));
    send_cmd(refresh_cmd(3, 2));
    send_cmd(clear_cmd());
    send_cmd(refresh_cmd(0, 0));
    send_cmd(refresh_cmd(7, 7));
    send_cmd(byte_cmd(5, 95, 'h80));
    send_cmd(byte_cmd(5, 80, 'h01));
    send_cmd(refresh_cmd(5, 5));
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      target    = items_sent + 80;
      while (items_sent < target) random_round();
      drain_results();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
